FILE: rtl/core/mabr_pkg.sv
// ----------------------------------------------------------------------------
// mabr_pkg
// Shared sizes, types and the arctangent table for the minimum-area
// enclosing rectangle block.
// ----------------------------------------------------------------------------
package mabr_pkg;

   localparam int MAX_POINTS   = 64;
   localparam int COORD_BITS   = 24;
   localparam int CNT_BITS     = $clog2(MAX_POINTS + 1);
   localparam int IDX_BITS     = $clog2(MAX_POINTS);

   // fixed-point scaling of the edge vector and of the direction quotient
   localparam int PRE_SH       = 40 - COORD_BITS;
   localparam int DIR_SH       = 54 - COORD_BITS;

   localparam int DIFF_W       = COORD_BITS + 1;
   localparam int LEN_W        = DIFF_W + PRE_SH + 3;
   localparam int DIR_W        = 16;
   localparam int ANG_W        = 17;
   localparam int ANGLE_W      = 16;
   localparam int PROJ_W       = COORD_BITS + DIR_W + 1;
   localparam int SPAN_W       = PROJ_W + 1;
   localparam int EXT_SH       = 14;
   localparam int EXT_W        = 25;
   localparam int AREA_W       = 52;
   localparam int PROD_W       = PROJ_W + DIR_W;
   localparam int CRN_SH       = 28;
   localparam int CRN_W        = PROD_W + 1 - CRN_SH;
   localparam int ORG_W        = 25;
   localparam int BOX_W        = 26;

   localparam int CORDIC_STEPS = 15;
   localparam int STEP_BITS    = 4;
   localparam int KINV_Q16     = 39797;

   localparam int QUO_W        = 16;
   localparam int QCNT_BITS    = $clog2(QUO_W);
   localparam int NUM_W        = DIFF_W + DIR_SH + 2;
   localparam int REM_W        = LEN_W + QUO_W + 1;

   localparam logic signed [ANG_W-1:0] ANG_PI  = 17'sd32768;
   localparam logic [QUO_W-1:0]        DIR_ONE = 16'd16384;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   // rounded atan(2^-s) in units of pi/32768
   function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_BITS-1:0] s);
      logic signed [ANG_W-1:0] r;
      case (s)
         4'd0:    r = 17'sd8192;
         4'd1:    r = 17'sd4836;
         4'd2:    r = 17'sd2555;
         4'd3:    r = 17'sd1297;
         4'd4:    r = 17'sd651;
         4'd5:    r = 17'sd326;
         4'd6:    r = 17'sd163;
         4'd7:    r = 17'sd81;
         4'd8:    r = 17'sd41;
         4'd9:    r = 17'sd20;
         4'd10:   r = 17'sd10;
         4'd11:   r = 17'sd5;
         4'd12:   r = 17'sd3;
         4'd13:   r = 17'sd1;
         4'd14:   r = 17'sd1;
         default: r = 17'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/core/mabr_cell.sv
// ----------------------------------------------------------------------------
// mabr_cell
// One vertex cell of the rotating vertex ring: loads a new vertex or takes
// the vertex of its neighbor.
// ----------------------------------------------------------------------------
module mabr_cell (
   input  logic                    clock,
   input  mabr_pkg::cell_ctrl_type ctrl,
   input  mabr_pkg::point_type     load_pt,
   input  mabr_pkg::point_type     nbr_pt,
   output mabr_pkg::point_type     pt
);
   import mabr_pkg::*;

   point_type pt_ff, pt_in;

   // load has priority, otherwise advance from the neighbor
   always_comb begin
      pt_in = pt_ff;
      if (ctrl.load) begin
         pt_in = load_pt;
      end else if (ctrl.shift) begin
         pt_in = nbr_pt;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
   end

   assign pt = pt_ff;

endmodule

FILE: rtl/core/mabr_cordic.sv
// ----------------------------------------------------------------------------
// mabr_cordic
// Iterative vectoring CORDIC: one rotation per cycle, then the gain
// correction multiply that gives the edge length.
// ----------------------------------------------------------------------------
module mabr_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [mabr_pkg::DIFF_W-1:0]  dx,
   input  logic signed [mabr_pkg::DIFF_W-1:0]  dy,
   output logic                                done,
   output logic [mabr_pkg::LEN_W-1:0]          len,
   output logic signed [mabr_pkg::ANG_W-1:0]   angle
);
   import mabr_pkg::*;

   logic signed [LEN_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic                    busy_ff, busy_in, mul_ff, mul_in, done_ff, done_in;
   logic [LEN_W-1:0]        len_ff, len_in;

   always_comb begin
      logic signed [LEN_W-1:0] x0, y0, xs, ys;
      logic [LEN_W+16:0]       rnd;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      mul_in  = 1'b0;
      done_in = 1'b0;
      len_in  = len_ff;
      x0      = LEN_W'(dx) <<< PRE_SH;
      y0      = LEN_W'(dy) <<< PRE_SH;
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      rnd     = (LEN_W+17)'($unsigned(x_ff)) * (LEN_W+17)'(KINV_Q16)
                + (LEN_W+17)'(32768);
      if (start) begin
         // fold the left half plane onto the right one
         x_in    = x0;
         y_in    = y0;
         z_in    = '0;
         if (dx < 0) begin
            x_in = -x0;
            y_in = -y0;
            z_in = (dy >= 0) ? ANG_PI : -ANG_PI;
         end
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // rotate toward the x axis
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_step(step_ff);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_step(step_ff);
         end
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            mul_in  = 1'b1;
         end
      end else if (mul_ff) begin
         // remove the CORDIC gain
         len_in  = rnd[16 +: LEN_W];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         mul_ff  <= mul_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      len_ff  <= len_in;
   end

   assign done  = done_ff;
   assign len   = len_ff;
   assign angle = z_ff;

endmodule

FILE: rtl/core/mabr_div.sv
// ----------------------------------------------------------------------------
// mabr_div
// Restoring divider, one quotient bit per cycle: rounded unit direction
// component from an edge component and the edge length, clamped to one.
// ----------------------------------------------------------------------------
module mabr_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mabr_pkg::DIFF_W-1:0]         mag,
   input  logic                                neg,
   input  logic [mabr_pkg::LEN_W-1:0]          len,
   output logic                                done,
   output logic signed [mabr_pkg::DIR_W-1:0]   quot
);
   import mabr_pkg::*;

   logic [REM_W-1:0]     rem_ff, rem_in, ds_ff, ds_in;
   logic [QUO_W-1:0]     q_ff, q_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic                 ovf_ff, ovf_in, neg_ff, neg_in;
   logic [QUO_W-1:0]     qmag;

   always_comb begin
      logic [NUM_W-1:0] num;
      logic [REM_W-1:0] den;
      logic             ge;
      rem_in  = rem_ff;
      ds_in   = ds_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      // 2*|d|*2^DIR_SH + len over 2*len gives round half away from zero
      num     = (NUM_W'(mag) << (DIR_SH + 1)) + NUM_W'(len);
      den     = REM_W'(len) << 1;
      ge      = rem_ff >= ds_ff;
      if (start) begin
         rem_in  = REM_W'(num);
         ds_in   = den << (QUO_W - 1);
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         ovf_in  = REM_W'(num) >= (den << QUO_W);
         neg_in  = neg;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - ds_ff;
         end
         q_in   = {q_ff[QUO_W-2:0], ge};
         ds_in  = ds_ff >> 1;
         cnt_in = cnt_ff + QCNT_BITS'(1);
         if (cnt_ff == QCNT_BITS'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      ds_ff  <= ds_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
   end

   // clamp to one, then apply the sign
   assign qmag = (ovf_ff || (q_ff > DIR_ONE)) ? DIR_ONE : q_ff;
   assign quot = neg_ff ? -$signed(qmag) : $signed(qmag);
   assign done = done_ff;

endmodule

FILE: rtl/core/min_area_bounding_rectangle.sv
// ----------------------------------------------------------------------------
// min_area_bounding_rectangle
// Edge-aligned minimum-area enclosing rectangle of a polygon held in a
// rotating ring of vertex cells.
// ----------------------------------------------------------------------------
//  Channel  Ports   Moves                         Direction
//  req      req_*   one polygon vertex            in
//  rsp      rsp_*   one rectangle per polygon     out
//
//  Loading accepts one vertex per cycle. After the marked vertex, each
//  polygon edge goes through a start step, the CORDIC, the dividers, a pass
//  in which the ring moves every vertex through the projection pipeline,
//  then drain, extent, area and the step to the next edge; the corner
//  products and the result follow.
//  Reset is synchronous; no clearing pass.
//  Vertices are accepted only while idle; loading goes on while a result
//  waits on a stalled rsp channel.
// ----------------------------------------------------------------------------
module min_area_bounding_rectangle (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [mabr_pkg::COORD_BITS-1:0]    req_point_x,
   input  logic signed [mabr_pkg::COORD_BITS-1:0]    req_point_y,
   input  logic                                      req_last_point,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_valid_res,
   output logic signed [mabr_pkg::ORG_W-1:0]         rsp_origin_x,
   output logic signed [mabr_pkg::ORG_W-1:0]         rsp_origin_y,
   output logic signed [mabr_pkg::DIR_W-1:0]         rsp_dir_x,
   output logic signed [mabr_pkg::DIR_W-1:0]         rsp_dir_y,
   output logic [mabr_pkg::EXT_W-1:0]                rsp_extent_u,
   output logic [mabr_pkg::EXT_W-1:0]                rsp_extent_v,
   output logic signed [mabr_pkg::ANGLE_W-1:0]       rsp_angle,
   output logic signed [mabr_pkg::BOX_W-1:0]         rsp_box_min_x,
   output logic signed [mabr_pkg::BOX_W-1:0]         rsp_box_max_x,
   output logic signed [mabr_pkg::BOX_W-1:0]         rsp_box_min_y,
   output logic signed [mabr_pkg::BOX_W-1:0]         rsp_box_max_y
);
   import mabr_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_EDGE   = 12'b0000_0000_0010,
      ST_CORDIC = 12'b0000_0000_0100,
      ST_DIV    = 12'b0000_0000_1000,
      ST_PROJ   = 12'b0000_0001_0000,
      ST_DRAIN  = 12'b0000_0010_0000,
      ST_EXT    = 12'b0000_0100_0000,
      ST_AREA   = 12'b0000_1000_0000,
      ST_NEXT   = 12'b0001_0000_0000,
      ST_CORN   = 12'b0010_0000_0000,
      ST_CSUM   = 12'b0100_0000_0000,
      ST_FIN    = 12'b1000_0000_0000
   } state_type;

   localparam int RAW_W = SPAN_W - EXT_SH;
   localparam int MUL_W = COORD_BITS + DIR_W;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in, n_ff, n_in, edge_ff, edge_in;
   logic [CNT_BITS-1:0]     kcnt_ff, kcnt_in, cnt_new, n_new;
   logic [2:0]              cn_ff, cn_in;
   point_type               last_ff, last_in, req_pt, last_new;
   point_type               cell_pt [MAX_POINTS];

   logic                    req_fire, room, store_en, dup;
   logic                    rotate, cordic_start, div_start, rsp_load, new_poly;

   logic signed [DIFF_W-1:0] dx_w, dy_w, dx_ff, dy_ff;
   logic                     cordic_done, div_done, div_y_done;
   logic [LEN_W-1:0]         cordic_len;
   logic signed [ANG_W-1:0]  cordic_ang, ang_ff;
   logic signed [DIR_W-1:0]  quot_x, quot_y, ux_ff, uy_ff;

   logic signed [MUL_W-1:0]  m_xux_ff, m_yuy_ff, m_yux_ff, m_xuy_ff;
   logic                     s1_valid_ff, pfirst_ff, pfirst_in;
   logic signed [PROJ_W-1:0] pu, pv;
   logic signed [PROJ_W-1:0] minu_ff, maxu_ff, minv_ff, maxv_ff;

   logic [EXT_W-1:0]         eu_ff, ev_ff;
   logic [AREA_W-1:0]        area_w, best_area_ff, best_area_in;
   logic                     best_upd, found_ff, found_in;
   logic signed [DIR_W-1:0]  bux_ff, buy_ff;
   logic [EXT_W-1:0]         beu_ff, bev_ff;
   logic signed [ANG_W-1:0]  bang_ff;
   logic signed [PROJ_W-1:0] bminu_ff, bmaxu_ff, bminv_ff, bmaxv_ff;

   logic signed [PROJ_W-1:0] cm_a;
   logic signed [DIR_W-1:0]  cm_b;
   logic signed [PROD_W-1:0] prod_ff [8];
   logic signed [CRN_W-1:0]  cx_ff [4];
   logic signed [CRN_W-1:0]  cy_ff [4];
   logic signed [CRN_W-1:0]  lox, hix, loy, hiy;

   logic                     rsp_valid_ff;
   logic                     rsp_res_ff;
   logic signed [ORG_W-1:0]  rsp_ox_ff, rsp_oy_ff;
   logic signed [DIR_W-1:0]  rsp_dx_ff, rsp_dy_ff;
   logic [EXT_W-1:0]         rsp_eu_ff, rsp_ev_ff;
   logic signed [ANGLE_W-1:0] rsp_ang_ff;
   logic signed [BOX_W-1:0]  rsp_bx0_ff, rsp_bx1_ff, rsp_by0_ff, rsp_by1_ff;

   // rounded extent of a projection span, saturated to the field
   function automatic logic [EXT_W-1:0] ext_sat(input logic signed [PROJ_W-1:0] hi,
                                                input logic signed [PROJ_W-1:0] lo);
      logic [SPAN_W-1:0] span;
      logic [RAW_W-1:0]  raw;
      span = $unsigned(SPAN_W'(hi) - SPAN_W'(lo)) + SPAN_W'(1 << (EXT_SH - 1));
      raw  = span[SPAN_W-1:EXT_SH];
      return (|raw[RAW_W-1:EXT_W]) ? {EXT_W{1'b1}} : raw[EXT_W-1:0];
   endfunction

   // corner coordinate from two Q.28 products, rounded to Q.0
   function automatic logic signed [CRN_W-1:0] crn_round(input logic signed [PROD_W-1:0] a,
                                                         input logic signed [PROD_W-1:0] b,
                                                         input logic sub);
      logic signed [PROD_W:0] s;
      s = sub ? ((PROD_W+1)'(a) - (PROD_W+1)'(b)) : ((PROD_W+1)'(a) + (PROD_W+1)'(b));
      s = s + ((PROD_W+1)'(1) <<< (CRN_SH - 1));
      s = s >>> CRN_SH;
      return s[CRN_W-1:0];
   endfunction

   function automatic logic signed [ORG_W-1:0] sat_org(input logic signed [CRN_W-1:0] v);
      if (v[CRN_W-1:ORG_W-1] == {(CRN_W-ORG_W+1){v[CRN_W-1]}}) begin
         return v[ORG_W-1:0];
      end
      return v[CRN_W-1] ? {1'b1, {(ORG_W-1){1'b0}}} : {1'b0, {(ORG_W-1){1'b1}}};
   endfunction

   function automatic logic signed [BOX_W-1:0] sat_box(input logic signed [CRN_W-1:0] v);
      if (v[CRN_W-1:BOX_W-1] == {(CRN_W-BOX_W+1){v[CRN_W-1]}}) begin
         return v[BOX_W-1:0];
      end
      return v[CRN_W-1] ? {1'b1, {(BOX_W-1){1'b0}}} : {1'b0, {(BOX_W-1){1'b1}}};
   endfunction

   // ---- input transfer and polygon size ----
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_pt    = '{x: req_point_x, y: req_point_y};
   assign room      = count_ff < CNT_BITS'(MAX_POINTS);
   assign store_en  = req_fire && room;
   assign cnt_new   = count_ff + CNT_BITS'(room);
   assign last_new  = room ? req_pt : last_ff;
   // drop a closing vertex equal to the first
   assign dup       = (cnt_new > CNT_BITS'(1)) && (last_new == cell_pt[0]);
   assign n_new     = cnt_new - CNT_BITS'(dup);
   assign last_in   = store_en ? req_pt : last_ff;

   // ---- vertex ring ----
   for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
      cell_ctrl_type ctrl;
      point_type     nbr;
      always_comb begin
         ctrl.load  = store_en && (count_ff[IDX_BITS-1:0] == IDX_BITS'(k));
         ctrl.shift = rotate && (CNT_BITS'(k) < n_ff);
         nbr        = (CNT_BITS'(k) == n_ff - CNT_BITS'(1)) ? cell_pt[0]
                                                           : cell_pt[(k + 1) % MAX_POINTS];
      end
      mabr_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .load_pt (req_pt),
         .nbr_pt  (nbr),
         .pt      (cell_pt[k])
      );
   end

   // ---- edge vector, length, angle and direction ----
   assign dx_w = DIFF_W'(cell_pt[1].x) - DIFF_W'(cell_pt[0].x);
   assign dy_w = DIFF_W'(cell_pt[1].y) - DIFF_W'(cell_pt[0].y);

   mabr_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .dx    (dx_w),
      .dy    (dy_w),
      .done  (cordic_done),
      .len   (cordic_len),
      .angle (cordic_ang)
   );

   mabr_div u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   ($unsigned(dx_ff[DIFF_W-1] ? -dx_ff : dx_ff)),
      .neg   (dx_ff[DIFF_W-1]),
      .len   (cordic_len),
      .done  (div_done),
      .quot  (quot_x)
   );

   mabr_div u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   ($unsigned(dy_ff[DIFF_W-1] ? -dy_ff : dy_ff)),
      .neg   (dy_ff[DIFF_W-1]),
      .len   (cordic_len),
      .done  (div_y_done),
      .quot  (quot_y)
   );

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      edge_in      = edge_ff;
      kcnt_in      = kcnt_ff;
      cn_in        = cn_ff;
      rotate       = 1'b0;
      cordic_start = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      new_poly     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in = cnt_new;
               if (req_last_point) begin
                  count_in = '0;
                  n_in     = n_new;
                  edge_in  = '0;
                  new_poly = 1'b1;
                  state_in = (n_new >= CNT_BITS'(3)) ? ST_EDGE : ST_FIN;
               end
            end
         end
         ST_EDGE: begin
            // skip a zero-length edge
            if ((dx_w == '0) && (dy_w == '0)) begin
               state_in = ST_NEXT;
            end else begin
               cordic_start = 1'b1;
               state_in     = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               if (cordic_len == '0) begin
                  state_in = ST_NEXT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done && div_y_done) begin
               kcnt_in  = '0;
               state_in = ST_PROJ;
            end
         end
         ST_PROJ: begin
            rotate  = 1'b1;
            kcnt_in = kcnt_ff + CNT_BITS'(1);
            if (kcnt_ff == n_ff - CNT_BITS'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_EXT;
         ST_EXT:   state_in = ST_AREA;
         ST_AREA:  state_in = ST_NEXT;
         ST_NEXT: begin
            rotate  = 1'b1;
            edge_in = edge_ff + CNT_BITS'(1);
            if (edge_ff == n_ff - CNT_BITS'(1)) begin
               cn_in    = '0;
               state_in = found_ff ? ST_CORN : ST_FIN;
            end else begin
               state_in = ST_EDGE;
            end
         end
         ST_CORN: begin
            cn_in = cn_ff + 3'd1;
            if (cn_ff == 3'd7) begin
               state_in = ST_CSUM;
            end
         end
         ST_CSUM: state_in = ST_FIN;
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- projection pipeline: multiply, then add and track extremes ----
   assign pu        = PROJ_W'(m_xux_ff) + PROJ_W'(m_yuy_ff);
   assign pv        = PROJ_W'(m_yux_ff) - PROJ_W'(m_xuy_ff);
   assign pfirst_in = (state_ff == ST_DIV && div_done) ? 1'b1
                    : (s1_valid_ff ? 1'b0 : pfirst_ff);

   // ---- area and best box ----
   assign area_w       = AREA_W'(eu_ff) * AREA_W'(ev_ff);
   assign best_upd     = (state_ff == ST_AREA) && (eu_ff != '0) && (ev_ff != '0)
                         && (area_w < best_area_ff);
   assign found_in     = new_poly ? 1'b0 : (best_upd ? 1'b1 : found_ff);
   assign best_area_in = new_poly ? {AREA_W{1'b1}} : (best_upd ? area_w : best_area_ff);

   // ---- corner products, one per cycle ----
   always_comb begin
      case (cn_ff)
         3'd0:    begin cm_a = bminu_ff; cm_b = bux_ff; end
         3'd1:    begin cm_a = bmaxu_ff; cm_b = bux_ff; end
         3'd2:    begin cm_a = bminv_ff; cm_b = buy_ff; end
         3'd3:    begin cm_a = bmaxv_ff; cm_b = buy_ff; end
         3'd4:    begin cm_a = bminu_ff; cm_b = buy_ff; end
         3'd5:    begin cm_a = bmaxu_ff; cm_b = buy_ff; end
         3'd6:    begin cm_a = bminv_ff; cm_b = bux_ff; end
         default: begin cm_a = bmaxv_ff; cm_b = bux_ff; end
      endcase
   end

   // ---- axis-aligned bound of the four corners ----
   always_comb begin
      lox = cx_ff[0];
      hix = cx_ff[0];
      loy = cy_ff[0];
      hiy = cy_ff[0];
      for (int c = 1; c < 4; c++) begin
         if (cx_ff[c] < lox) lox = cx_ff[c];
         if (cx_ff[c] > hix) hix = cx_ff[c];
         if (cy_ff[c] < loy) loy = cy_ff[c];
         if (cy_ff[c] > hiy) hiy = cy_ff[c];
      end
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         pfirst_ff    <= 1'b0;
         found_ff     <= 1'b0;
         best_area_ff <= {AREA_W{1'b1}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         s1_valid_ff  <= (state_ff == ST_PROJ);
         pfirst_ff    <= pfirst_in;
         found_ff     <= found_in;
         best_area_ff <= best_area_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- data path registers ----
   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      edge_ff <= edge_in;
      kcnt_ff <= kcnt_in;
      cn_ff   <= cn_in;
      last_ff <= last_in;
      if (state_ff == ST_EDGE) begin
         dx_ff <= dx_w;
         dy_ff <= dy_w;
      end
      if (state_ff == ST_CORDIC && cordic_done) begin
         ang_ff <= cordic_ang;
      end
      if (state_ff == ST_DIV && div_done) begin
         ux_ff <= quot_x;
         uy_ff <= quot_y;
      end
      // products of the vertex at the head of the ring
      m_xux_ff <= $signed(cell_pt[0].x) * ux_ff;
      m_yuy_ff <= $signed(cell_pt[0].y) * uy_ff;
      m_yux_ff <= $signed(cell_pt[0].y) * ux_ff;
      m_xuy_ff <= $signed(cell_pt[0].x) * uy_ff;
      if (s1_valid_ff) begin
         if (pfirst_ff || pu < minu_ff) minu_ff <= pu;
         if (pfirst_ff || pu > maxu_ff) maxu_ff <= pu;
         if (pfirst_ff || pv < minv_ff) minv_ff <= pv;
         if (pfirst_ff || pv > maxv_ff) maxv_ff <= pv;
      end
      if (state_ff == ST_EXT) begin
         eu_ff <= ext_sat(maxu_ff, minu_ff);
         ev_ff <= ext_sat(maxv_ff, minv_ff);
      end
      if (best_upd) begin
         bux_ff   <= ux_ff;
         buy_ff   <= uy_ff;
         beu_ff   <= eu_ff;
         bev_ff   <= ev_ff;
         bang_ff  <= ang_ff;
         bminu_ff <= minu_ff;
         bmaxu_ff <= maxu_ff;
         bminv_ff <= minv_ff;
         bmaxv_ff <= maxv_ff;
      end
      if (state_ff == ST_CORN) begin
         prod_ff[cn_ff] <= cm_a * cm_b;
      end
      // corners: (min,min), (max,min), (max,max), (min,max)
      if (state_ff == ST_CSUM) begin
         cx_ff[0] <= crn_round(prod_ff[0], prod_ff[2], 1'b1);
         cy_ff[0] <= crn_round(prod_ff[4], prod_ff[6], 1'b0);
         cx_ff[1] <= crn_round(prod_ff[1], prod_ff[2], 1'b1);
         cy_ff[1] <= crn_round(prod_ff[5], prod_ff[6], 1'b0);
         cx_ff[2] <= crn_round(prod_ff[1], prod_ff[3], 1'b1);
         cy_ff[2] <= crn_round(prod_ff[5], prod_ff[7], 1'b0);
         cx_ff[3] <= crn_round(prod_ff[0], prod_ff[3], 1'b1);
         cy_ff[3] <= crn_round(prod_ff[4], prod_ff[7], 1'b0);
      end
      // result register, all zero when no box was found
      if (rsp_load) begin
         rsp_res_ff <= found_ff;
         if (found_ff) begin
            rsp_ox_ff  <= sat_org(cx_ff[0]);
            rsp_oy_ff  <= sat_org(cy_ff[0]);
            rsp_dx_ff  <= bux_ff;
            rsp_dy_ff  <= buy_ff;
            rsp_eu_ff  <= beu_ff;
            rsp_ev_ff  <= bev_ff;
            rsp_ang_ff <= bang_ff[ANGLE_W-1:0];
            rsp_bx0_ff <= sat_box(lox);
            rsp_bx1_ff <= sat_box(hix);
            rsp_by0_ff <= sat_box(loy);
            rsp_by1_ff <= sat_box(hiy);
         end else begin
            rsp_ox_ff  <= '0;
            rsp_oy_ff  <= '0;
            rsp_dx_ff  <= '0;
            rsp_dy_ff  <= '0;
            rsp_eu_ff  <= '0;
            rsp_ev_ff  <= '0;
            rsp_ang_ff <= '0;
            rsp_bx0_ff <= '0;
            rsp_bx1_ff <= '0;
            rsp_by0_ff <= '0;
            rsp_by1_ff <= '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;
   assign rsp_origin_x  = rsp_ox_ff;
   assign rsp_origin_y  = rsp_oy_ff;
   assign rsp_dir_x     = rsp_dx_ff;
   assign rsp_dir_y     = rsp_dy_ff;
   assign rsp_extent_u  = rsp_eu_ff;
   assign rsp_extent_v  = rsp_ev_ff;
   assign rsp_angle     = rsp_ang_ff;
   assign rsp_box_min_x = rsp_bx0_ff;
   assign rsp_box_max_x = rsp_bx1_ff;
   assign rsp_box_min_y = rsp_by0_ff;
   assign rsp_box_max_y = rsp_by1_ff;

endmodule

FILE: rtl/core/mabr_checker.sv
// ----------------------------------------------------------------------------
// mabr_checker
// Port-level checks on the rectangle result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mabr_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_valid,
   input logic                                      req_ready,
   input logic signed [mabr_pkg::COORD_BITS-1:0]    req_point_x,
   input logic signed [mabr_pkg::COORD_BITS-1:0]    req_point_y,
   input logic                                      req_last_point,
   input logic                                      rsp_valid,
   input logic                                      rsp_ready,
   input logic                                      rsp_valid_res,
   input logic signed [mabr_pkg::ORG_W-1:0]         rsp_origin_x,
   input logic signed [mabr_pkg::ORG_W-1:0]         rsp_origin_y,
   input logic signed [mabr_pkg::DIR_W-1:0]         rsp_dir_x,
   input logic signed [mabr_pkg::DIR_W-1:0]         rsp_dir_y,
   input logic [mabr_pkg::EXT_W-1:0]                rsp_extent_u,
   input logic [mabr_pkg::EXT_W-1:0]                rsp_extent_v,
   input logic signed [mabr_pkg::ANGLE_W-1:0]       rsp_angle,
   input logic signed [mabr_pkg::BOX_W-1:0]         rsp_box_min_x,
   input logic signed [mabr_pkg::BOX_W-1:0]         rsp_box_max_x,
   input logic signed [mabr_pkg::BOX_W-1:0]         rsp_box_min_y,
   input logic signed [mabr_pkg::BOX_W-1:0]         rsp_box_max_y
);
   import mabr_pkg::*;

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays valid with its extent_u and angle unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_extent_u) && $stable(rsp_angle))
      else $error("stalled result changed");

   // no box found: extents, direction, origin_x and angle are zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_extent_u == '0 && rsp_extent_v == '0
         && rsp_dir_x == '0 && rsp_dir_y == '0 && rsp_origin_x == '0 && rsp_angle == '0)
      else $error("empty result carries data");

   // a found box is never degenerate
   a_box_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_extent_u != '0 && rsp_extent_v != '0)
      else $error("degenerate box reported");

   // the bound is ordered
   a_bound_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_box_min_x <= rsp_box_max_x
         && rsp_box_min_y <= rsp_box_max_y)
      else $error("bound corners out of order");

endmodule

bind min_area_bounding_rectangle mabr_checker u_mabr_checker (.*);

FILE: verif/min_area_bounding_rectangle_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_area_bounding_rectangle_chk
// Watches the vertex and rectangle channels, keeps its own copy of the
// polygon, works out the expected rectangle on every marked vertex and
// compares each rectangle transfer against the oldest expected one.
// ----------------------------------------------------------------------------
module min_area_bounding_rectangle_chk
   import mabr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic                         req_last_point,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_valid_res,
   input  logic signed [ORG_W-1:0]      rsp_origin_x,
   input  logic signed [ORG_W-1:0]      rsp_origin_y,
   input  logic signed [DIR_W-1:0]      rsp_dir_x,
   input  logic signed [DIR_W-1:0]      rsp_dir_y,
   input  logic [EXT_W-1:0]             rsp_extent_u,
   input  logic [EXT_W-1:0]             rsp_extent_v,
   input  logic signed [ANGLE_W-1:0]    rsp_angle,
   input  logic signed [BOX_W-1:0]      rsp_box_min_x,
   input  logic signed [BOX_W-1:0]      rsp_box_max_x,
   input  logic signed [BOX_W-1:0]      rsp_box_min_y,
   input  logic signed [BOX_W-1:0]      rsp_box_max_y,
   output int                           fail_count,
   output int                           rect_pending
);

   typedef struct packed {
      logic                      valid_res;
      logic signed [ORG_W-1:0]   origin_x;
      logic signed [ORG_W-1:0]   origin_y;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic [EXT_W-1:0]          extent_u;
      logic [EXT_W-1:0]          extent_v;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [BOX_W-1:0]   box_min_x;
      logic signed [BOX_W-1:0]   box_max_x;
      logic signed [BOX_W-1:0]   box_min_y;
      logic signed [BOX_W-1:0]   box_max_y;
   } rect_type;

   longint   poly_x [MAX_POINTS];
   longint   poly_y [MAX_POINTS];
   int       poly_len;
   rect_type rect_fifo [$];

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // round half away from zero
   function automatic longint div_round(longint a, longint d);
      longint unsigned m, q;
      m = a < 0 ? longint'(-a) : a;
      q = (2 * m + d) / (2 * d);
      return a < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint span_extent(longint span);
      longint e;
      e = (span + 8192) >>> EXT_SH;
      return e > 33554431 ? 33554431 : e;
   endfunction

   function automatic rect_type min_rect();
      rect_type r;
      int       n, j;
      bit       found;
      longint dx, dy, x, y, z, xs, ys, len, ux, uy;
      longint minu, maxu, minv, maxv, pu, pv, eu, ev, area, best;
      longint bux, buy, beu, bev, bang, bminu, bmaxu, bminv, bmaxv;
      longint cu [4];
      longint cv [4];
      longint cx, cy, lox, hix, loy, hiy;
      r = '0;
      found = 0;
      best = (longint'(1) << AREA_W) - 1;
      bux = 0; buy = 0; beu = 0; bev = 0; bang = 0;
      bminu = 0; bmaxu = 0; bminv = 0; bmaxv = 0;
      n = poly_len;
      // drop a closing vertex equal to the first
      if (n > 1 && poly_x[n-1] == poly_x[0] && poly_y[n-1] == poly_y[0])
         n--;
      for (int i = 0; n >= 3 && i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         dx = poly_x[j] - poly_x[i];
         dy = poly_y[j] - poly_y[i];
         if (dx == 0 && dy == 0)
            continue;
         x = dx <<< PRE_SH;
         y = dy <<< PRE_SH;
         z = 0;
         if (x < 0) begin
            z = (y >= 0) ? 32768 : -32768;
            x = -x;
            y = -y;
         end
         // vectoring CORDIC
         for (int s = 0; s < CORDIC_STEPS; s++) begin
            xs = x >>> s;
            ys = y >>> s;
            if (y > 0) begin
               x += ys; y -= xs; z += longint'(atan_tab(s));
            end else begin
               x -= ys; y += xs; z -= longint'(atan_tab(s));
            end
         end
         len = (x * KINV_Q16 + 32768) >>> 16;
         if (len == 0)
            continue;
         ux = clamp(div_round(dx <<< DIR_SH, len), -16384, 16384);
         uy = clamp(div_round(dy <<< DIR_SH, len), -16384, 16384);
         minu = poly_x[0] * ux + poly_y[0] * uy;
         maxu = minu;
         minv = poly_y[0] * ux - poly_x[0] * uy;
         maxv = minv;
         for (int k = 1; k < n; k++) begin
            pu = poly_x[k] * ux + poly_y[k] * uy;
            pv = poly_y[k] * ux - poly_x[k] * uy;
            if (pu < minu) minu = pu;
            if (pu > maxu) maxu = pu;
            if (pv < minv) minv = pv;
            if (pv > maxv) maxv = pv;
         end
         eu = span_extent(maxu - minu);
         ev = span_extent(maxv - minv);
         if (eu == 0 || ev == 0)
            continue;
         area = eu * ev;
         // strict less: ties stay with the first edge
         if (area < best) begin
            best = area; found = 1;
            bux = ux; buy = uy; beu = eu; bev = ev; bang = z;
            bminu = minu; bmaxu = maxu; bminv = minv; bmaxv = maxv;
         end
      end
      if (!found)
         return r;
      cu[0] = bminu; cv[0] = bminv;
      cu[1] = bmaxu; cv[1] = bminv;
      cu[2] = bmaxu; cv[2] = bmaxv;
      cu[3] = bminu; cv[3] = bmaxv;
      lox = 0; hix = 0; loy = 0; hiy = 0;
      for (int c = 0; c < 4; c++) begin
         cx = (cu[c] * bux - cv[c] * buy + (longint'(1) << 27)) >>> CRN_SH;
         cy = (cu[c] * buy + cv[c] * bux + (longint'(1) << 27)) >>> CRN_SH;
         if (c == 0) begin
            lox = cx; hix = cx; loy = cy; hiy = cy;
            r.origin_x = clamp(cx, -16777216, 16777215);
            r.origin_y = clamp(cy, -16777216, 16777215);
         end
         if (cx < lox) lox = cx;
         if (cx > hix) hix = cx;
         if (cy < loy) loy = cy;
         if (cy > hiy) hiy = cy;
      end
      r.valid_res = 1'b1;
      r.dir_x     = bux;
      r.dir_y     = buy;
      r.extent_u  = beu;
      r.extent_v  = bev;
      r.angle     = bang;
      r.box_min_x = clamp(lox, -33554432, 33554431);
      r.box_max_x = clamp(hix, -33554432, 33554431);
      r.box_min_y = clamp(loy, -33554432, 33554431);
      r.box_max_y = clamp(hiy, -33554432, 33554431);
      return r;
   endfunction

   function automatic longint atan_tab(int s);
      case (s)
         0: return 8192;    1: return 4836;  2: return 2555;  3: return 1297;
         4: return 651;     5: return 326;   6: return 163;   7: return 81;
         8: return 41;      9: return 20;    10: return 10;   11: return 5;
         12: return 3;      default: return 1;
      endcase
   endfunction

   assign rect_pending = rect_fifo.size();

   // store vertices, predict on the marked one, compare rectangle transfers
   always @(posedge clock) begin
      rect_type want;
      if (reset) begin
         poly_len   = 0;
         fail_count <= 0;
         rect_fifo.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (poly_len < MAX_POINTS) begin
               poly_x[poly_len] = req_point_x;
               poly_y[poly_len] = req_point_y;
               poly_len = poly_len + 1;
            end
            if (req_last_point) begin
               rect_fifo.push_back(min_rect());
               poly_len = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (rect_fifo.size() == 0) begin
               $error("rectangle transfer with none expected");
               fail_count <= fail_count + 1;
            end else begin
               want = rect_fifo.pop_front();
               if (want !== {rsp_valid_res, rsp_origin_x, rsp_origin_y, rsp_dir_x,
                             rsp_dir_y, rsp_extent_u, rsp_extent_v, rsp_angle,
                             rsp_box_min_x, rsp_box_max_x, rsp_box_min_y,
                             rsp_box_max_y}) begin
                  fail_count <= fail_count + 1;
                  if (want.valid_res !== rsp_valid_res)
                     $error("valid_res exp %0d got %0d", want.valid_res, rsp_valid_res);
                  if (want.origin_x !== rsp_origin_x)
                     $error("origin_x exp %0d got %0d", want.origin_x, rsp_origin_x);
                  if (want.origin_y !== rsp_origin_y)
                     $error("origin_y exp %0d got %0d", want.origin_y, rsp_origin_y);
                  if (want.dir_x !== rsp_dir_x)
                     $error("dir_x exp %0d got %0d", want.dir_x, rsp_dir_x);
                  if (want.dir_y !== rsp_dir_y)
                     $error("dir_y exp %0d got %0d", want.dir_y, rsp_dir_y);
                  if (want.extent_u !== rsp_extent_u)
                     $error("extent_u exp %0d got %0d", want.extent_u, rsp_extent_u);
                  if (want.extent_v !== rsp_extent_v)
                     $error("extent_v exp %0d got %0d", want.extent_v, rsp_extent_v);
                  if (want.angle !== rsp_angle)
                     $error("angle exp %0d got %0d", want.angle, rsp_angle);
                  if (want.box_min_x !== rsp_box_min_x)
                     $error("box_min_x exp %0d got %0d", want.box_min_x, rsp_box_min_x);
                  if (want.box_max_x !== rsp_box_max_x)
                     $error("box_max_x exp %0d got %0d", want.box_max_x, rsp_box_max_x);
                  if (want.box_min_y !== rsp_box_min_y)
                     $error("box_min_y exp %0d got %0d", want.box_min_y, rsp_box_min_y);
                  if (want.box_max_y !== rsp_box_max_y)
                     $error("box_max_y exp %0d got %0d", want.box_max_y, rsp_box_max_y);
               end
            end
         end
      end
   end

endmodule

FILE: verif/min_area_bounding_rectangle_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_area_bounding_rectangle_tb
// Feeds directed and random polygons into the block with random gaps and
// back-pressure; the checker predicts and compares every rectangle.
// ----------------------------------------------------------------------------
module min_area_bounding_rectangle_tb;
   import mabr_pkg::*;

   localparam int ITEM_TARGET = 1550;
   localparam int IDLE_LIMIT  = 60000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [COORD_BITS-1:0] req_point_x = '0;
   logic signed [COORD_BITS-1:0] req_point_y = '0;
   logic                         req_last_point = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_valid_res;
   logic signed [ORG_W-1:0]      rsp_origin_x, rsp_origin_y;
   logic signed [DIR_W-1:0]      rsp_dir_x, rsp_dir_y;
   logic [EXT_W-1:0]             rsp_extent_u, rsp_extent_v;
   logic signed [ANGLE_W-1:0]    rsp_angle;
   logic signed [BOX_W-1:0]      rsp_box_min_x, rsp_box_max_x;
   logic signed [BOX_W-1:0]      rsp_box_min_y, rsp_box_max_y;
   int                           fail_count, rect_pending;
   int                           items_sent;
   int                           idle_cycles;
   bit                           stim_done;
   logic signed [COORD_BITS-1:0] px [$];
   logic signed [COORD_BITS-1:0] py [$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   min_area_bounding_rectangle u_top (.*);

   min_area_bounding_rectangle_chk u_chk (.*);

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // transfer one vertex; valid drops only for a gap
   task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y, input logic last);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_point_x    <= x;
      req_point_y    <= y;
      req_last_point <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // send the queued polygon, marking the final vertex
   task automatic send_poly();
      for (int i = 0; i < px.size(); i++)
         send_point(px[i], py[i], i == px.size() - 1);
      px.delete();
      py.delete();
   endtask

   task automatic add(input int x, input int y);
      px.push_back(x);
      py.push_back(y);
   endtask

   // random polygon: mostly well formed, some noise and broken shapes
   task automatic random_poly();
      int n, kind, cx, cy, rad, ang;
      kind = $urandom_range(0, 99);
      n = (kind < 3) ? $urandom_range(62, 67) : $urandom_range(3, 10);
      rad = 1 << $urandom_range(4, 21);
      cx = $signed($urandom) >>> 10;
      cy = $signed($urandom) >>> 10;
      if (kind >= 3 && kind < 8) n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
         if (kind >= 8 && kind < 18) begin
            add($urandom, $urandom);
         end else if (kind >= 18 && kind < 23) begin
            add(cx + i * (rad >> 4), cy + i * (rad >> 5));
         end else begin
            ang = $urandom_range(0, 359);
            add(cx + $signed($urandom_range(0, rad)) * $cos(ang * 0.01745),
                cy + $signed($urandom_range(0, rad)) * $sin(ang * 0.01745));
         end
         if (kind >= 23 && kind < 30 && $urandom_range(0, 3) == 0)
            add(px[px.size()-1], py[py.size()-1]);
      end
      if (kind >= 30 && kind < 42)
         add(px[0], py[0]);
      send_poly();
   endtask

   // random back-pressure on the rectangle channel
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 8)
         rsp_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 60)
         rsp_ready <= 1'b1;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (stim_done || req_valid || rect_pending != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** min_area_bounding_rectangle: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      items_sent = 0;
      stim_done  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes of the coordinate range
      add(-8388608, -8388608); add(8388607, -8388608); add(0, 8388607);
      send_poly();
      // square with a closing vertex equal to the first
      add(0, 0); add(256, 0); add(256, 256); add(0, 256); add(0, 0);
      send_poly();
      // too few vertices
      add(5, 5); send_poly();
      add(5, 5); add(900, -3); send_poly();
      // zero-length edge
      add(0, 0); add(0, 0); add(1000, 0); add(0, 1000);
      send_poly();
      // collinear points give a degenerate box
      add(0, 0); add(100, 0); add(200, 0);
      send_poly();
      // edge pointing along minus x gives an angle of pi
      add(1000, 0); add(0, 0); add(500, 700);
      send_poly();

      while (items_sent < ITEM_TARGET)
         random_poly();

      // drop valid after the last transfer
      req_valid <= 1'b0;
      stim_done = 1;
      while (rect_pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("** min_area_bounding_rectangle: PASSED **");
      else
         $display("** min_area_bounding_rectangle: FAILED **");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/mabr_pkg.sv
rtl/core/mabr_cell.sv
rtl/core/mabr_cordic.sv
rtl/core/mabr_div.sv
rtl/core/min_area_bounding_rectangle.sv
rtl/core/mabr_checker.sv
verif/min_area_bounding_rectangle_chk.sv
verif/min_area_bounding_rectangle_tb.sv
